// ----- src/gbfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfr_pkg
// Shared types and constants for the binary frame receiver: parse phases,
// sync and register codes, and the result record.
// ----------------------------------------------------------------------------
package gbfr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Register word index on the configuration port
  localparam logic REG_CLASS_FILTER = 1'b0;
  localparam logic [7:0] CLASS_FILTER_RESET = 8'h01;

  // Output item kinds
  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_CLASS  = 3'd2,
    PH_ID     = 3'd3,
    PH_LEN_LO = 3'd4,
    PH_LEN_HI = 3'd5,
    PH_BODY   = 3'd6
  } phase_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  message_id;
    logic [15:0] payload_length;
    logic        checksum_ok;
    logic        frame_last;
  } result_t;

endpackage : gbfr_pkg
`default_nettype wire

// ----- src/gbfr_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfr_cfg_regs
// Register port holding the class filter; writes on the access phase.
// ----------------------------------------------------------------------------
module gbfr_cfg_regs
  import gbfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [7:0]  class_filter
);

  logic [7:0] class_filter_r;
  logic       wr_en;
  logic       sel_class;

  assign pready    = 1'b1;
  assign sel_class = (paddr[2] == REG_CLASS_FILTER);
  assign wr_en     = psel && penable && pwrite && pready;

  // Update the class filter on a completed write request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_filter_r <= CLASS_FILTER_RESET;
    end else if (wr_en && sel_class) begin
      class_filter_r <= pwdata[7:0];
    end
  end

  // Read back; unmapped words read zero
  always_comb begin
    prdata = 32'd0;
    if (sel_class) begin
      prdata = {24'd0, class_filter_r};
    end
  end

  assign class_filter = class_filter_r;

endmodule : gbfr_cfg_regs
`default_nettype wire

// ----- src/gbfr_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfr_parser
// Frame state machine with running Fletcher-8 sums; one byte per cycle while
// byte_valid is high, producing at most one result record per byte.
// ----------------------------------------------------------------------------
module gbfr_parser
  import gbfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_valid,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] class_filter,
  output logic            res_valid,
  output result_t         res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] len_r, len_nxt;
  logic [16:0] remain_r, remain_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  ck_a_r, ck_a_nxt;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [7:0]  cls_a;
  logic [7:0]  cls_b;

  // Fletcher step on the current sums, and restart from zero for the class
  assign add_a = sum_a_r + rx_byte;
  assign add_b = sum_b_r + add_a;
  assign cls_a = rx_byte;
  assign cls_b = rx_byte;

  // Hold parse state between bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      id_r     <= 8'd0;
      len_lo_r <= 8'd0;
      len_r    <= 16'd0;
      remain_r <= 17'd0;
      sum_a_r  <= 8'd0;
      sum_b_r  <= 8'd0;
      ck_a_r   <= 8'd0;
    end else if (byte_valid) begin
      phase_r  <= phase_nxt;
      id_r     <= id_nxt;
      len_lo_r <= len_lo_nxt;
      len_r    <= len_nxt;
      remain_r <= remain_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      ck_a_r   <= ck_a_nxt;
    end
  end

  // Next phase, sums and result for the byte at hand
  always_comb begin
    phase_nxt  = phase_r;
    id_nxt     = id_r;
    len_lo_nxt = len_lo_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    ck_a_nxt   = ck_a_r;
    res_valid  = 1'b0;

    res.item_kind      = KIND_PAYLOAD;
    res.payload_byte   = 8'd0;
    res.payload_index  = 16'd0;
    res.message_id     = id_r;
    res.payload_length = len_r;
    res.checksum_ok    = 1'b0;
    res.frame_last     = 1'b0;

    case (phase_r)
      PH_SYNC2: begin
        phase_nxt = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
      end
      PH_CLASS: begin
        if (rx_byte == class_filter) begin
          sum_a_nxt = cls_a;
          sum_b_nxt = cls_b;
          phase_nxt = PH_ID;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_ID: begin
        id_nxt    = rx_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_lo_nxt = rx_byte;
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt    = {rx_byte, len_lo_r};
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
        remain_nxt = {1'b0, rx_byte, len_lo_r} + 17'd2;
        phase_nxt  = PH_BODY;
      end
      PH_BODY: begin
        if (remain_r > 17'd2) begin
          // Pass a payload byte through with its position
          sum_a_nxt         = add_a;
          sum_b_nxt         = add_b;
          remain_nxt        = remain_r - 17'd1;
          res_valid         = 1'b1;
          res.payload_byte  = rx_byte;
          res.payload_index = len_r - remain_r[15:0] + 16'd2;
        end else if (remain_r == 17'd2) begin
          // Capture the first check byte
          ck_a_nxt   = rx_byte;
          remain_nxt = 17'd1;
        end else begin
          // Second check byte closes the frame with the verdict
          res_valid       = 1'b1;
          res.item_kind   = KIND_FRAME_END;
          res.checksum_ok = (ck_a_r == sum_a_r) && (rx_byte == sum_b_r);
          res.frame_last  = 1'b1;
          remain_nxt      = 17'd0;
          phase_nxt       = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
      end
    endcase

    if (!byte_valid) begin
      res_valid = 1'b0;
    end
  end

endmodule : gbfr_parser
`default_nettype wire

// ----- src/gbfr_out_skid.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfr_out_skid
// Output register with one skid entry, so the input side keeps taking bytes
// while a result waits at the output, until the skid entry is also filled.
// ----------------------------------------------------------------------------
module gbfr_out_skid
  import gbfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  result_t      push_data,
  output logic         space,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    out_v_r;
  logic    skid_v_r;
  result_t out_d_r;
  result_t skid_d_r;
  logic    out_free;

  assign out_free = !out_v_r || out_ready;
  assign space    = !skid_v_r;

  // Track occupancy of the output and skid entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // Move result records; the skid drains first to keep order
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_d_r <= skid_v_r ? skid_d_r : push_data;
    end else if (push) begin
      skid_d_r <= push_data;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule : gbfr_out_skid
`default_nettype wire

// ----- src/gnss_binary_frame_receiver_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A result is registered in the output register, or in the skid entry while the output is held.
// Throughput: one byte per cycle while the skid entry is free; the parse state machine settles each byte.
// A one-entry skid behind the output register keeps bytes flowing while a result waits, until it fills.
// Reset (synchronous, rst_n low): hunting for the first sync, sums and counts cleared,
// output empty, class filter set to 1.
// ----------------------------------------------------------------------------
// gnss_binary_frame_receiver_top
// Sync hunt, class filter, header capture, cut-through payload and Fletcher-8
// verdict for a stream of received serial bytes.
// ----------------------------------------------------------------------------
module gnss_binary_frame_receiver_top
  import gbfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream; tdata: [7:0] rx_byte
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  // Result stream; tdata: [7:0] payload_byte, [23:8] payload_index,
  // [31:24] message_id, [47:32] payload_length, [48] checksum_ok, [55:49] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [55:0] out_tdata,
  // tuser: [0] item_kind
  output logic      [0:0]  out_tuser,
  output logic             out_tlast,
  // Register port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  logic [7:0] class_filter_w;
  logic       in_fire;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  gbfr_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .class_filter (class_filter_w)
  );

  // Take a byte request whenever the skid entry is free
  assign in_fire = in_tvalid && in_tready;

  gbfr_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (in_fire),
    .rx_byte      (in_tdata),
    .class_filter (class_filter_w),
    .res_valid    (res_valid),
    .res          (res)
  );

  gbfr_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // Pack the result record onto the stream
  assign out_tdata = {7'd0, out_res.checksum_ok, out_res.payload_length,
                      out_res.message_id, out_res.payload_index,
                      out_res.payload_byte};
  assign out_tuser = out_res.item_kind;
  assign out_tlast = out_res.frame_last;

endmodule : gnss_binary_frame_receiver_top
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives received bytes into the binary frame receiver and checks every
// payload and frame-end result against a cycle-free model of the parser.
// Covers sync hunting, class filtering, zero-length and long frames, and
// checksum verdicts under several class settings and back-pressure mixes.
// ----------------------------------------------------------------------------
module testbench;
  import gbfr_pkg::*;

  localparam logic [2:0] CLASS_FILTER_ADDR = {REG_CLASS_FILTER, 2'b00};

  // Check-byte handling for generated frames
  localparam int CK_GOOD  = 0;
  localparam int CK_BAD_A = 1;
  localparam int CK_BAD_B = 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  gnss_binary_frame_receiver_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Parser model state
  phase_t      prs_phase = PH_HUNT;
  logic [7:0]  prs_id = 8'h00;
  logic [7:0]  prs_len_lo = 8'h00;
  logic [15:0] prs_len = 16'h0000;
  logic [16:0] prs_remaining = 17'd0;
  logic [7:0]  ck_a = 8'h00;
  logic [7:0]  ck_b = 8'h00;
  logic [7:0]  rx_ck_a = 8'h00;
  logic [7:0]  class_sel = CLASS_FILTER_RESET;

  result_t due_results[$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      sink_stall_pct = 0;
  int      frame_bytes_sent = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void fold_sum(input logic [7:0] b);
    ck_a = ck_a + b;
    ck_b = ck_b + ck_a;
  endfunction

  // Advance the parser model by one byte; return 1 when a result is due
  function automatic bit predict_frame_byte(input logic [7:0] b, output result_t r);
    bit produced;
    produced = 1'b0;
    r = '0;
    case (prs_phase)
      PH_SYNC2: prs_phase = (b == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
      PH_CLASS: begin
        if (b == class_sel) begin
          ck_a = 8'h00;
          ck_b = 8'h00;
          fold_sum(b);
          prs_phase = PH_ID;
        end else begin
          prs_phase = PH_HUNT;
        end
      end
      PH_ID: begin
        prs_id = b;
        fold_sum(b);
        prs_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        prs_len_lo = b;
        fold_sum(b);
        prs_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        prs_len = {b, prs_len_lo};
        fold_sum(b);
        prs_remaining = {1'b0, prs_len} + 17'd2;
        prs_phase = PH_BODY;
      end
      PH_BODY: begin
        if (prs_remaining > 17'd2) begin
          fold_sum(b);
          r.item_kind     = KIND_PAYLOAD;
          r.payload_byte  = b;
          r.payload_index = prs_len - 16'(prs_remaining - 17'd2);
          r.message_id    = prs_id;
          r.payload_length = prs_len;
          produced = 1'b1;
          prs_remaining = prs_remaining - 17'd1;
        end else if (prs_remaining == 17'd2) begin
          rx_ck_a = b;
          prs_remaining = 17'd1;
        end else begin
          r.item_kind      = KIND_FRAME_END;
          r.message_id     = prs_id;
          r.payload_length = prs_len;
          r.checksum_ok    = (rx_ck_a == ck_a) && (b == ck_b);
          r.frame_last     = 1'b1;
          produced = 1'b1;
          prs_remaining = 17'd0;
          prs_phase = PH_HUNT;
        end
      end
      default: prs_phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
    endcase
    return produced;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Randomize receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t seen;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.item_kind      = out_tuser[0];
      seen.payload_byte   = out_tdata[7:0];
      seen.payload_index  = out_tdata[23:8];
      seen.message_id     = out_tdata[31:24];
      seen.payload_length = out_tdata[47:32];
      seen.checksum_ok    = out_tdata[48];
      seen.frame_last     = out_tlast;
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing due", seen, 0);
      end else begin
        want = due_results.pop_front();
        if (seen.item_kind != want.item_kind)
          report_mismatch("item_kind", seen.item_kind, want.item_kind);
        if (seen.payload_byte != want.payload_byte)
          report_mismatch("payload_byte", seen.payload_byte, want.payload_byte);
        if (seen.payload_index != want.payload_index)
          report_mismatch("payload_index", seen.payload_index, want.payload_index);
        if (seen.message_id != want.message_id)
          report_mismatch("message_id", seen.message_id, want.message_id);
        if (seen.payload_length != want.payload_length)
          report_mismatch("payload_length", seen.payload_length, want.payload_length);
        if (seen.checksum_ok != want.checksum_ok)
          report_mismatch("checksum_ok", seen.checksum_ok, want.checksum_ok);
        if (seen.frame_last != want.frame_last)
          report_mismatch("frame_last", seen.frame_last, want.frame_last);
      end
      if (out_tdata[55:49] != 7'd0)
        report_mismatch("tdata padding", out_tdata[55:49], 0);
    end
  end

  // Send one byte request; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    if (predict_frame_byte(b, r))
      due_results.push_back(r);
    @(negedge clk);
  endtask

  // Build a full frame with its Fletcher check bytes, optionally spoiled
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id, input int len,
                            input int ck_mode);
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [7:0]  b;
    logic [15:0] ln;
    logic [7:0]  hdr[4];
    ln = 16'(len);
    hdr = '{cls, id, ln[7:0], ln[15:8]};
    sa = 8'h00;
    sb = 8'h00;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    foreach (hdr[i]) begin
      sa = sa + hdr[i];
      sb = sb + sa;
      send_byte(hdr[i]);
    end
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      sa = sa + b;
      sb = sb + sa;
      send_byte(b);
    end
    if (ck_mode == CK_BAD_A) sa = sa ^ 8'($urandom_range(1, 255));
    if (ck_mode == CK_BAD_B) sb = sb ^ 8'($urandom_range(1, 255));
    send_byte(sa);
    send_byte(sb);
    frame_bytes_sent += len + 8;
  endtask

  // Drop valid, wait for every result, then let the pipeline settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic read_class_filter(output logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CLASS_FILTER_ADDR;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    value = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write the class filter, then read it back
  task automatic write_class_filter(input logic [7:0] cls);
    logic [31:0] rd;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CLASS_FILTER_ADDR;
    cfg_pwdata  <= {24'd0, cls};
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    class_sel = cls;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    read_class_filter(rd);
    if (rd != {24'd0, cls})
      report_mismatch("class_filter readback", rd, cls);
  endtask

  task automatic test_reset_value();
    logic [31:0] rd;
    read_class_filter(rd);
    if (rd != {24'd0, CLASS_FILTER_RESET})
      report_mismatch("class_filter reset", rd, CLASS_FILTER_RESET);
  endtask

  // Noise, a repeated first sync, and a header with a foreign class
  task automatic test_sync_hunt();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(class_sel + 8'd1);
  endtask

  // Empty payload: only the verdict comes out
  task automatic test_zero_length();
    send_frame(class_sel, 8'hFF, 0, CK_GOOD);
  endtask

  task automatic test_bad_checksum();
    send_frame(class_sel, 8'h00, 1, CK_BAD_A);
  endtask

  // Mostly well-formed frames, with broken headers, spoiled checks and noise
  task automatic test_random_traffic(input int n_bytes, input int idle_pct,
                                     input int stall_pct);
    int          stop_at;
    int          pick;
    int          len;
    logic [7:0]  b;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    stop_at = frame_bytes_sent + n_bytes;
    while (frame_bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      len = ($urandom_range(49) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 20);
      if (pick < 70) begin
        send_frame(class_sel, 8'($urandom_range(255)), len, CK_GOOD);
      end else if (pick < 80) begin
        send_frame(class_sel, 8'($urandom_range(255)), len % 21,
                   ($urandom_range(1)) ? CK_BAD_A : CK_BAD_B);
      end else if (pick < 88) begin
        do b = 8'($urandom_range(255)); while (b == class_sel);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(b);
        frame_bytes_sent += 3;
      end else if (pick < 94) begin
        do b = 8'($urandom_range(255)); while (b == SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(b);
        frame_bytes_sent += 2;
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_value();
    send_idle_pct  = 22;
    sink_stall_pct = 72;
    test_sync_hunt();
    test_zero_length();
    test_bad_checksum();
    drain_results();

    write_class_filter(8'h00);
    test_random_traffic(400, 22, 72);
    write_class_filter(8'hFF);
    test_random_traffic(400, 72, 22);
    write_class_filter(SYNC_FIRST);
    test_random_traffic(200, 0, 0);
    write_class_filter(8'($urandom_range(255)));
    test_random_traffic(200, 0, 0);

    if (due_results.size() != 0)
      report_mismatch("results never delivered", due_results.size(), 0);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/gbfr_pkg.sv
src/gbfr_cfg_regs.sv
src/gbfr_parser.sv
src/gbfr_out_skid.sv
src/gnss_binary_frame_receiver_top.sv
dv/testbench.sv
